>>> sv/uqsd_pkg.sv
package uqsd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_QUERY   = 8'h3F;  // '?'
  localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
  localparam logic [7:0] CH_EQUAL   = 8'h3D;  // '='
  localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '

  localparam logic [7:0] MAX_PAIRS_RESET = 8'd32;
  localparam logic [8:0] PAIR_CNT_MAX    = 9'd511;

  // Result queue: deep enough to take one full burst of three results
  // while one older result is still waiting.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int MAX_EMIT = 3;

  typedef enum logic [1:0] {
    PH_PRE   = 2'd0,
    PH_NAME  = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  typedef enum logic [1:0] {
    KIND_NAME     = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PAIR_END = 2'd2,
    KIND_TGT_END  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_CAPACITY = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic [7:0] pair_index;
    status_t    status;
    logic       last;
  } result_t;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) v = {1'b0, 4'(c - 8'h30)};
    else if (c inside {[8'h41:8'h46]}) v = {1'b0, 4'(c - 8'h37)};
    else if (c inside {[8'h61:8'h66]}) v = {1'b0, 4'(c - 8'h57)};
    return v;
  endfunction

  function automatic logic [7:0] pair_idx(input logic [8:0] cnt);
    logic [7:0] v;
    if (cnt == 9'd0) v = 8'd0;
    else if (cnt > 9'd256) v = 8'd255;
    else v = 8'(cnt - 9'd1);
    return v;
  endfunction

  function automatic status_t cur_status(input logic [8:0] cnt, input logic err,
                                         input logic [7:0] max_pairs);
    status_t s;
    if (cnt > {1'b0, max_pairs}) s = ST_CAPACITY;
    else if (err) s = ST_INVALID;
    else s = ST_OK;
    return s;
  endfunction

endpackage

>>> sv/url_query_splitter_decoder_top.sv
// URL query splitter and percent decoder.
// Input channel (in_valid / in_stall): one raw byte of a request target per
// transaction, in_last on the final byte. Bytes before the first '?' are
// skipped; the query is split on '&' into pairs and on the first '=' into
// name and value. '+' becomes a space, %XX becomes one byte.
// Result channel (out_valid / out_stall): decoded name/value bytes, a pair-end
// marker per pair and a target-end marker (out_last) carrying final status.
// A byte causes zero to three results.
// Results of a byte are queued when it is taken and reach the port behind any
// older results. Throughput: one byte per cycle while it yields at most one
// result and the result side does not stall; the sustained rate is set by the
// single-result-per-cycle output port.
// A four-entry result queue sits between decode logic and the output; the
// input is stalled only when the queue could not absorb a full burst of three.
// cfg_wr_en writes max_pairs (reset 32); write it only while idle.
// Reset (rst_n low, synchronous) empties the queue, returns the parser to
// "before '?'" and restores max_pairs. A stall on the result side holds the
// queue head and, once more than one result waits, back-pressures the input.
module url_query_splitter_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [7:0] out_pair_index,
  output logic [1:0] out_status,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import uqsd_pkg::*;

  // Parser state
  phase_t      phase_r, phase_nxt;
  esc_t        esc_r, esc_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [8:0]  pcnt_r, pcnt_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  max_pairs_r;

  // Result queue
  result_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   q_cnt_r;

  result_t             slot [MAX_EMIT];
  logic [1:0]          n_emit;

  logic in_acc, out_pop;

  assign out_valid = (q_cnt_r != '0);
  assign out_pop   = out_valid && !out_stall;
  // Accept only when a full burst fits after this cycle's pop.
  assign in_stall  = (q_cnt_r > QCNT_W'(QDEPTH - MAX_EMIT) + QCNT_W'(out_pop));
  assign in_acc    = in_valid && !in_stall;

  // Decode one byte: next state plus up to three results, in order.
  always_comb begin
    logic [4:0] h;
    kind_t      dkind;
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    hi_nxt    = hi_r;
    pcnt_nxt  = pcnt_r;
    err_nxt   = err_r;
    n_emit    = 2'd0;
    h         = hex_val(in_byte);
    dkind     = (phase_r == PH_VALUE) ? KIND_VALUE : KIND_NAME;
    for (int k = 0; k < MAX_EMIT; k++) begin
      slot[k] = '0;
    end

    if (phase_r == PH_PRE) begin
      if (in_byte == CH_QUERY) phase_nxt = PH_NAME;
    end else begin
      if (pcnt_nxt == 9'd0) pcnt_nxt = 9'd1;
      if (in_byte == CH_AMP) begin
        if (esc_r != ESC_NONE) err_nxt = 1'b1;
        esc_nxt = ESC_NONE;
        slot[n_emit] = '{8'd0, KIND_PAIR_END, pair_idx(pcnt_nxt),
                         cur_status(pcnt_nxt, err_nxt, max_pairs_r), 1'b0};
        n_emit = n_emit + 2'd1;
        if (pcnt_nxt < PAIR_CNT_MAX) pcnt_nxt = pcnt_nxt + 9'd1;
        phase_nxt = PH_NAME;
      end else if (in_byte == CH_EQUAL && phase_r == PH_NAME) begin
        if (esc_r != ESC_NONE) err_nxt = 1'b1;
        esc_nxt   = ESC_NONE;
        phase_nxt = PH_VALUE;
      end else if (esc_r == ESC_HIGH) begin
        if (h[4]) begin
          err_nxt = 1'b1;
          esc_nxt = ESC_NONE;
        end else begin
          hi_nxt  = h[3:0];
          esc_nxt = ESC_LOW;
        end
      end else if (esc_r == ESC_LOW) begin
        esc_nxt = ESC_NONE;
        if (h[4]) begin
          err_nxt = 1'b1;
        end else begin
          slot[n_emit] = '{{hi_r, h[3:0]}, dkind, pair_idx(pcnt_nxt),
                           cur_status(pcnt_nxt, err_nxt, max_pairs_r), 1'b0};
          n_emit = n_emit + 2'd1;
        end
      end else if (in_byte == CH_PERCENT) begin
        esc_nxt = ESC_HIGH;
      end else begin
        slot[n_emit] = '{(in_byte == CH_PLUS) ? CH_SPACE : in_byte, dkind,
                         pair_idx(pcnt_nxt),
                         cur_status(pcnt_nxt, err_nxt, max_pairs_r), 1'b0};
        n_emit = n_emit + 2'd1;
      end
    end

    if (in_last) begin
      if (pcnt_nxt != 9'd0) begin
        if (esc_nxt != ESC_NONE) err_nxt = 1'b1;
        slot[n_emit] = '{8'd0, KIND_PAIR_END, pair_idx(pcnt_nxt),
                         cur_status(pcnt_nxt, err_nxt, max_pairs_r), 1'b0};
        n_emit = n_emit + 2'd1;
      end
      slot[n_emit] = '{8'd0, KIND_TGT_END, pair_idx(pcnt_nxt),
                       cur_status(pcnt_nxt, err_nxt, max_pairs_r), 1'b1};
      n_emit = n_emit + 2'd1;
      // Drop all parser state for the next target.
      phase_nxt = PH_PRE;
      esc_nxt   = ESC_NONE;
      hi_nxt    = 4'd0;
      pcnt_nxt  = 9'd0;
      err_nxt   = 1'b0;
    end
  end

  // Parser state advances only on an accepted byte; the config register loads on cfg_wr_en.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PRE;
      esc_r       <= ESC_NONE;
      hi_r        <= 4'd0;
      pcnt_r      <= 9'd0;
      err_r       <= 1'b0;
      max_pairs_r <= MAX_PAIRS_RESET;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        esc_r   <= esc_nxt;
        hi_r    <= hi_nxt;
        pcnt_r  <= pcnt_nxt;
        err_r   <= err_nxt;
      end
      if (cfg_wr_en) max_pairs_r <= cfg_wr_data;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (in_acc) wr_ptr_r <= wr_ptr_r + QPTR_W'(n_emit);
      if (out_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      q_cnt_r <= q_cnt_r + (in_acc ? QCNT_W'(n_emit) : QCNT_W'(0))
                 - QCNT_W'(out_pop);
    end
  end

  // Queue storage: write the burst at consecutive slots.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < MAX_EMIT; k++) begin
        if (2'(k) < n_emit) q_mem_r[wr_ptr_r + QPTR_W'(k)] <= slot[k];
      end
    end
  end

  assign out_byte       = q_mem_r[rd_ptr_r].data;
  assign out_kind       = q_mem_r[rd_ptr_r].kind;
  assign out_pair_index = q_mem_r[rd_ptr_r].pair_index;
  assign out_status     = q_mem_r[rd_ptr_r].status;
  assign out_last       = q_mem_r[rd_ptr_r].last;

`ifndef ASSERT_OFF
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> phase_r == PH_PRE && pcnt_r == 9'd0 && err_r == 1'b0)
    else $error("parser state not cleared after target end");

  a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> out_valid)
    else $error("target end produced no result");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_TGT_END)
    else $error("out_last on a non target-end result");
`endif

endmodule

>>> dv/uqsd_checker.sv
module uqsd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_pair_index,
  input  logic [1:0] out_status,
  input  logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output int         fail_count,
  output int         owed_count
);
  import uqsd_pkg::*;

  // Parser copy, advanced once per accepted input transaction.
  phase_t     ph;
  esc_t       esc_stage;
  logic [3:0] hi_nibble;
  logic [8:0] pairs_seen;
  logic       esc_err;
  logic [7:0] limit_pairs;

  result_t owed_results[$];

  initial begin
    fail_count = 0;
    owed_count = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch, %s", $time, what);
    fail_count++;
  endtask

  // Bit 4 flags a byte that is not a hex digit; letters are case-folded.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] v;
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= "0" && c <= "9") v = {1'b0, c[3:0]};
    else if (lc >= "a" && lc <= "f") v = {1'b0, lc[3:0] + 4'd9};
    else v = 5'h10;
    return v;
  endfunction

  task automatic owe_result(input logic [7:0] b, input kind_t k, input logic fin);
    result_t r;
    r.data = b;
    r.kind = k;
    if (pairs_seen == 9'd0) r.pair_index = 8'd0;
    else if (pairs_seen >= 9'd256) r.pair_index = 8'd255;
    else r.pair_index = 8'(pairs_seen - 9'd1);
    // Capacity wins over a bad escape.
    if (pairs_seen > {1'b0, limit_pairs}) r.status = ST_CAPACITY;
    else if (esc_err) r.status = ST_INVALID;
    else r.status = ST_OK;
    r.last = fin;
    owed_results.push_back(r);
  endtask

  // A boundary hit with an escape still open marks the target invalid.
  task automatic abandon_escape();
    if (esc_stage != ESC_NONE) esc_err = 1'b1;
    esc_stage = ESC_NONE;
  endtask

  task automatic clear_parser();
    ph = PH_PRE;
    esc_stage = ESC_NONE;
    hi_nibble = 4'd0;
    pairs_seen = 9'd0;
    esc_err = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [4:0] nib;
    kind_t      dk;
    dk = (ph == PH_VALUE) ? KIND_VALUE : KIND_NAME;
    if (ph == PH_PRE) begin
      if (b == CH_QUERY) ph = PH_NAME;
    end else begin
      if (pairs_seen == 9'd0) pairs_seen = 9'd1;
      if (b == CH_AMP) begin
        abandon_escape();
        owe_result(8'h00, KIND_PAIR_END, 1'b0);
        if (pairs_seen != PAIR_CNT_MAX) pairs_seen = pairs_seen + 9'd1;
        ph = PH_NAME;
      end else if (b == CH_EQUAL && ph == PH_NAME) begin
        abandon_escape();
        ph = PH_VALUE;
      end else if (esc_stage == ESC_HIGH) begin
        nib = hex_nibble(b);
        if (nib[4]) begin
          esc_err = 1'b1;
          esc_stage = ESC_NONE;
        end else begin
          hi_nibble = nib[3:0];
          esc_stage = ESC_LOW;
        end
      end else if (esc_stage == ESC_LOW) begin
        nib = hex_nibble(b);
        esc_stage = ESC_NONE;
        if (nib[4]) esc_err = 1'b1;
        else owe_result({hi_nibble, nib[3:0]}, dk, 1'b0);
      end else if (b == CH_PERCENT) begin
        esc_stage = ESC_HIGH;
      end else if (b == CH_PLUS) begin
        owe_result(CH_SPACE, dk, 1'b0);
      end else begin
        owe_result(b, dk, 1'b0);
      end
    end
    if (fin) begin
      if (pairs_seen != 9'd0) begin
        abandon_escape();
        owe_result(8'h00, KIND_PAIR_END, 1'b0);
      end
      owe_result(8'h00, KIND_TGT_END, 1'b1);
      clear_parser();
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_parser();
      limit_pairs = MAX_PAIRS_RESET;
      owed_results.delete();
    end else begin
      if (cfg_wr_en) limit_pairs = cfg_wr_data;
      if (in_valid && !in_stall) decode_byte(in_byte, in_last);
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte=%0d kind=%0d",
                                    out_byte, out_kind));
        end else begin
          want = owed_results.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte got %0d expected %0d",
                                      out_byte, want.data));
          if (out_kind !== want.kind)
            report_mismatch($sformatf("out_kind got %0d expected %0d",
                                      out_kind, want.kind));
          if (out_pair_index !== want.pair_index)
            report_mismatch($sformatf("out_pair_index got %0d expected %0d",
                                      out_pair_index, want.pair_index));
          if (out_status !== want.status)
            report_mismatch($sformatf("out_status got %0d expected %0d",
                                      out_status, want.status));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last got %0d expected %0d",
                                      out_last, want.last));
        end
      end
    end
    owed_count <= owed_results.size();
  end

endmodule

>>> dv/tb_top.sv
module tb_top;
  import uqsd_pkg::*;

  // Quiet cycles tolerated before the run is declared hung. The longest
  // legitimate quiet stretch is the receiver's long hold-off.
  localparam int WATCHDOG_LIMIT = 2000;
  // Extra cycles after the last owed result: lets a byte that yields no
  // result clear the pipeline before the register is touched.
  localparam int SETTLE_CYCLES  = 6;
  localparam int LONG_HOLD      = 80;
  localparam int PHASE_BYTES    = 16;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [7:0] out_pair_index;
  logic [1:0] out_status;
  logic       out_last;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  int fail_count;
  int owed_count;

  // Idle rates in percent of cycles, set per phase by the stimulus thread.
  int send_idle_pct;
  int recv_idle_pct;

  // Long receiver hold-off: requested by the stimulus, counted by the receiver.
  logic hold_go;
  int   hold_count;
  bit   hold_done;

  int         bytes_sent;
  int         quiet_cycles;
  logic [7:0] tgt_q[$];

  url_query_splitter_decoder_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_pair_index(out_pair_index),
    .out_status    (out_status),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  uqsd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_pair_index(out_pair_index),
    .out_status    (out_status),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .owed_count    (owed_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Byte generators
  // ---------------------------------------------------------------------

  // Any byte that is not a separator, escape or plus; optionally not '?'.
  function automatic logic [7:0] plain_byte(input bit allow_query);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_AMP || c == CH_EQUAL || c == CH_PERCENT || c == CH_PLUS ||
           (!allow_query && c == CH_QUERY));
    return c;
  endfunction

  // Hex digit for a nibble, letters in random case.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = "0" + 8'(n);
    else c = (($urandom_range(1) != 0) ? "a" : "A") + 8'(n - 4'd10);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    logic [7:0] lc;
    do begin
      c = plain_byte(1'b1);
      lc = c | 8'h20;
    end while ((c >= "0" && c <= "9") || (lc >= "a" && lc <= "f"));
    return c;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) tgt_q.push_back(s[i]);
  endfunction

  // Leave an escape open right before a boundary now and then.
  function automatic void maybe_cut_escape();
    if ($urandom_range(15) == 0) begin
      tgt_q.push_back(CH_PERCENT);
      if ($urandom_range(1) != 0) tgt_q.push_back(hex_char(4'($urandom)));
    end
  endfunction

  // One decoded element: plain byte, plus, good escape, '=' inside a value, or a broken escape.
  function automatic void push_element(input bit in_value);
    int         r;
    logic [7:0] v;
    r = $urandom_range(99);
    v = 8'($urandom);
    if (r < 55) begin
      tgt_q.push_back(plain_byte(1'b1));
    end else if (r < 65) begin
      tgt_q.push_back(CH_PLUS);
    end else if (r < 85) begin
      tgt_q.push_back(CH_PERCENT);
      tgt_q.push_back(hex_char(v[7:4]));
      tgt_q.push_back(hex_char(v[3:0]));
    end else if (r < 90 && in_value) begin
      tgt_q.push_back(CH_EQUAL);
    end else if (r < 95) begin
      tgt_q.push_back(CH_PERCENT);
      tgt_q.push_back(non_hex_byte());
    end else begin
      tgt_q.push_back(CH_PERCENT);
      tgt_q.push_back(hex_char(v[7:4]));
      tgt_q.push_back(non_hex_byte());
    end
  endfunction

  function automatic void push_pair();
    int n;
    n = $urandom_range(4);
    repeat (n) push_element(1'b0);
    if ($urandom_range(3) != 0) begin
      maybe_cut_escape();
      tgt_q.push_back(CH_EQUAL);
      n = $urandom_range(5);
      repeat (n) push_element(1'b1);
    end
    maybe_cut_escape();
  endfunction

  // Mostly well-formed targets with random content; some raw noise and
  // some targets without any query mark.
  function automatic void build_random_target();
    int r;
    int n;
    int np;
    tgt_q.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      n = $urandom_range(1, 10);
      repeat (n) tgt_q.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(4);
      repeat (n) tgt_q.push_back(plain_byte(1'b0));
      if (r >= 14) begin
        tgt_q.push_back(CH_QUERY);
        np = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        for (int i = 0; i < np; i++) begin
          if (i != 0) tgt_q.push_back(CH_AMP);
          push_pair();
        end
        // Trailing '&' opens a final empty pair.
        if (np != 0 && $urandom_range(7) == 0) tgt_q.push_back(CH_AMP);
      end
    end
    if (tgt_q.size() == 0) tgt_q.push_back(plain_byte(1'b0));
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Offer one byte, idling first at the phase's rate, and hold it until the
  // transaction completes. Return at the accepting edge with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_target();
    foreach (tgt_q[i]) send_byte(tgt_q[i], i == tgt_q.size() - 1);
    tgt_q.delete();
  endtask

  // Drop valid, wait until every owed result has come out, then let the
  // pipeline drain a few more cycles.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_pairs(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_random_phase();
    int goal;
    goal = bytes_sent + PHASE_BYTES;
    while (bytes_sent < goal) begin
      build_random_target();
      send_target();
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall at the phase's rate, plus one long hold-off
  // that lets the result queue fill and back up into the input.
  // ---------------------------------------------------------------------
  initial begin
    out_stall  = 1'b0;
    hold_count = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        hold_count++;
        if (hold_count == LONG_HOLD) hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: count cycles in which no transaction moves on either channel.
  // ---------------------------------------------------------------------
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    in_last       = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 8'h00;
    hold_go       = 1'b0;
    bytes_sent    = 0;
    send_idle_pct = 22;
    recv_idle_pct = 81;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a limit of two pairs so the capacity check fires early.
    write_max_pairs(8'd2);
    // Prefix skip, '+', upper- and lower-case escapes, '=' inside a value,
    // trailing '&' giving a third, empty pair over the limit.
    push_text("x?+%4A=%7e=&&");
    send_target();
    // Query mark with nothing after it: target end only.
    push_text("?");
    send_target();
    // Bad hex digit in a name, '?' as value data, escape cut off by the end.
    push_text("?%G=?%4");
    send_target();
    // Byte extremes as name data, escape closing exactly at the end.
    push_text("?");
    tgt_q.push_back(8'h00);
    tgt_q.push_back(8'hFF);
    push_text("%41");
    send_target();
    settle();

    // Sender idles lightly, receiver heavily; smallest limit.
    write_max_pairs(8'd1);
    run_random_phase();
    settle();

    // Roles swapped; largest limit, plus one target long enough to push
    // the pair index into saturation and past the limit.
    send_idle_pct = 81;
    recv_idle_pct = 22;
    write_max_pairs(8'd255);
    tgt_q.push_back(CH_QUERY);
    repeat (270) tgt_q.push_back(CH_AMP);
    send_target();
    run_random_phase();
    settle();

    // No idling; open with the long receiver hold-off while bytes keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max_pairs(8'($urandom_range(2, 6)));
    hold_go <= 1'b1;
    run_random_phase();
    settle();

    if (fail_count == 0 && owed_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
